### rtl/stream_pattern_replace_core_assert.svh
// Assertion macros for the stream pattern replace core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication under clock and active-low reset.
`define SPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spr assertion failed");
// Next-cycle implication under clock and active-low reset.
`define SPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spr assertion failed");
`else
`define SPR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/spr_pkg.sv
// Shared constants, types and helpers for the stream pattern replace core.
// No dependencies.
package spr_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_REPLACE = 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH = 2'd3;

	// One result handed from the sequencer to the output register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       marker;
	} out_push_t;

	function automatic logic [7:0] byte_at(input logic [63:0] word, input logic [2:0] idx);
		byte_at = word[{idx, 3'b000} +: 8];
	endfunction

endpackage

### rtl/stream_pattern_replace_core.sv
// Top level of the stream pattern replace core: configuration registers,
// output register and the sequencer. Depends on spr_pkg and spr_seq.

// Streaming find-and-replace on a byte stream. Each accepted input transaction
// carries one byte (or an end-of-stream flag); every complete, leftmost,
// non-overlapping occurrence of the configured pattern (1..8 bytes) is replaced
// by the configured replacement (0..8 bytes) and all other bytes pass through.
// Only the match count is held; on a mismatch the count falls back along the
// pattern's borders, emitting the bytes that drop out of the prefix. An
// end-of-stream transaction flushes the held prefix and then sends one end
// marker (out_byte 0, is_end_marker 1). last_of_run flags the final result of
// each input transaction; a transaction that only extends a partial match, or
// completes one with an empty replacement, produces no result. Timing: the
// sequencer takes one item at a time and in_stall stays high while it works.
// A byte that passes straight through or extends a match is accepted,
// compared and finished. Each fallback compares, tries the border candidates
// one at a time (at most m for a count of m, the empty border included) and
// emits the bytes that drop out; a completed match emits each replacement
// byte; a flush emits each held byte plus the marker. Results leave through
// one output register, so downstream stalls hold the sequencer only when it
// has a new result ready. Configuration writes are always taken (cfg_ready is
// high) and must be issued while the core is idle.
module stream_pattern_replace_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          stream_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          last_of_run,
	output logic                          is_end_marker
);
	import spr_pkg::*;

	logic [63:0] pattern_q;
	logic [3:0]  pat_len_q;
	logic [63:0] replace_q;
	logic [3:0]  rep_len_q;
	logic [3:0]  pat_len_eff;
	logic [3:0]  rep_len_eff;
	logic        out_free;
	out_push_t   push;

	assign cfg_ready = 1'b1;

	// Saturate the lengths: zero pattern length acts as one.
	always_comb begin
		if (pat_len_q == 4'd0)
			pat_len_eff = 4'd1;
		else if (pat_len_q > 4'(MAX_PATTERN))
			pat_len_eff = 4'(MAX_PATTERN);
		else
			pat_len_eff = pat_len_q;
		rep_len_eff = (rep_len_q > 4'(MAX_REPLACE)) ? 4'(MAX_REPLACE) : rep_len_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= 64'd0;
			pat_len_q <= 4'd1;
			replace_q <= 64'd0;
			rep_len_q <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: pat_len_q <= cfg_data[3:0];
				REG_REPLACE_BYTES:  replace_q <= cfg_data;
				REG_REPLACE_LENGTH: rep_len_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	spr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.pattern    (pattern_q),
		.pat_len    (pat_len_eff),
		.replace    (replace_q),
		.rep_len    (rep_len_eff),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.out_free   (out_free),
		.push       (push)
	);

	// Output register: free when empty or when its transaction leaves now.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (push.valid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Hold the payload while stalled; load a new result only when free.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_byte      <= push.data;
			last_of_run   <= push.last;
			is_end_marker <= push.marker;
		end
	end

endmodule

### rtl/spr_cmp.sv
// Border compare unit: checks whether the first k pattern bytes equal the
// k bytes ending just before position m. Depends on spr_pkg.
module spr_cmp (
	input  logic [63:0] pattern,
	input  logic [3:0]  m,
	input  logic [2:0]  k,
	output logic        eq
);
	import spr_pkg::*;

	always_comb begin
		logic [2:0] pos;
		eq  = 1'b1;
		pos = 3'd0;
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			pos = m[2:0] - k + 3'(i);
			if (3'(i) < k && byte_at(pattern, 3'(i)) != byte_at(pattern, pos))
				eq = 1'b0;
		end
	end

endmodule

### rtl/spr_seq.sv
// Sequencer of the stream pattern replace core: match count, prefix fallback,
// replacement and flush emission. Depends on spr_pkg, spr_cmp and the assert header.
`include "stream_pattern_replace_core_assert.svh"

module spr_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [63:0]           pattern,
	input  logic [3:0]            pat_len,
	input  logic [63:0]           replace,
	input  logic [3:0]            rep_len,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte,
	input  logic                  stream_end,
	input  logic                  out_free,
	output spr_pkg::out_push_t    push
);
	import spr_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MATCH  = 3'd1;
	localparam logic [2:0] S_BORDER = 3'd2;
	localparam logic [2:0] S_EMITF  = 3'd3;
	localparam logic [2:0] S_REPL   = 3'd4;
	localparam logic [2:0] S_FLUSH  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [3:0] mc_q;
	logic [2:0] k_q;
	logic [2:0] idx_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic       pend_v_q;
	logic [7:0] pend_data_q;
	logic       pend_mark_q;

	logic       hit;
	logic       bord_eq;
	logic       emit_req;
	logic [7:0] emit_data;
	logic       emit_mark;
	logic       can_emit;
	logic       accept;
	logic [3:0] mc_clamped;

	spr_cmp u_cmp (
		.pattern (pattern),
		.m       (mc_q),
		.k       (k_q),
		.eq      (bord_eq)
	);

	assign hit        = byte_at(pattern, mc_q[2:0]) == byte_q;
	assign can_emit   = !pend_v_q || out_free;
	assign in_stall   = state_q != S_IDLE;
	assign accept     = in_valid && !in_stall;
	assign mc_clamped = (mc_q >= pat_len) ? pat_len - 4'd1 : mc_q;

	always_comb begin
		emit_req  = 1'b0;
		emit_data = 8'h00;
		emit_mark = 1'b0;
		unique case (state_q)
			S_MATCH: begin
				if (!end_q && !hit && mc_q == 4'd0) begin
					emit_req  = 1'b1;
					emit_data = byte_q;
				end
			end
			S_EMITF: begin
				emit_req  = 1'b1;
				emit_data = byte_at(pattern, idx_q);
			end
			S_REPL: begin
				emit_req  = 1'b1;
				emit_data = byte_at(replace, idx_q);
			end
			S_FLUSH: begin
				emit_req = 1'b1;
				if ({1'b0, idx_q} < mc_q)
					emit_data = byte_at(pattern, idx_q);
				else
					emit_mark = 1'b1;
			end
			default: ;
		endcase
	end

	// Push the held result once the next one exists, or as last at the end.
	always_comb begin
		push        = '0;
		push.data   = pend_data_q;
		push.marker = pend_mark_q;
		if (emit_req && can_emit && pend_v_q) begin
			push.valid = 1'b1;
		end else if (state_q == S_DONE && pend_v_q && out_free) begin
			push.valid = 1'b1;
			push.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mc_q     <= 4'd0;
			k_q      <= 3'd0;
			idx_q    <= 3'd0;
			pend_v_q <= 1'b0;
		end else begin
			if (emit_req && can_emit)
				pend_v_q <= 1'b1;
			else if (state_q == S_DONE && out_free)
				pend_v_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mc_q    <= mc_clamped;
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (end_q) begin
						idx_q   <= 3'd0;
						state_q <= S_FLUSH;
					end else if (hit) begin
						if (mc_q + 4'd1 == pat_len) begin
							mc_q    <= 4'd0;
							idx_q   <= 3'd0;
							state_q <= (rep_len == 4'd0) ? S_DONE : S_REPL;
						end else begin
							mc_q    <= mc_q + 4'd1;
							state_q <= S_DONE;
						end
					end else if (mc_q == 4'd0) begin
						if (can_emit)
							state_q <= S_DONE;
					end else begin
						k_q     <= mc_q[2:0] - 3'd1;
						state_q <= S_BORDER;
					end
				end
				S_BORDER: begin
					if (k_q == 3'd0 || bord_eq) begin
						idx_q   <= 3'd0;
						state_q <= S_EMITF;
					end else begin
						k_q <= k_q - 3'd1;
					end
				end
				S_EMITF: begin
					if (can_emit) begin
						if ({1'b0, idx_q} == mc_q - {1'b0, k_q} - 4'd1) begin
							mc_q    <= {1'b0, k_q};
							state_q <= S_MATCH;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				S_REPL: begin
					if (can_emit) begin
						if ({1'b0, idx_q} == rep_len - 4'd1)
							state_q <= S_DONE;
						else
							idx_q <= idx_q + 3'd1;
					end
				end
				S_FLUSH: begin
					if (can_emit) begin
						if ({1'b0, idx_q} < mc_q) begin
							idx_q <= idx_q + 3'd1;
						end else begin
							mc_q    <= 4'd0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!pend_v_q || out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_byte;
			end_q  <= stream_end;
		end
		if (emit_req && can_emit) begin
			pend_data_q <= emit_data;
			pend_mark_q <= emit_mark;
		end
	end

	`SPR_ASSERT_IMP(a_idle_no_pending, clk, arst_n, state_q == S_IDLE, !pend_v_q)
	`SPR_ASSERT_IMP(a_count_below_max, clk, arst_n, 1'b1, mc_q[3] == 1'b0)
	`SPR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, in_stall)
	`SPR_ASSERT_IMP(a_push_needs_room, clk, arst_n, push.valid, out_free)

endmodule
